// ===== rtl/core/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Types, constants and the shared divider step for the RGB to HSL pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 11;
	localparam int SAT_W      = 13;
	localparam int LIGHT_W    = 9;

	// quotient bits per divider: saturation up to 4096, hue fraction up to 256
	localparam int SAT_QBITS  = 13;
	localparam int HUE_QBITS  = 9;

	localparam logic [LIGHT_W-1:0] LIGHT_HALF = 9'd255;
	localparam logic [LIGHT_W-1:0] LIGHT_FULL = 9'd510;
	localparam logic [11:0]        HUE_FULL   = 12'd1536;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [SAT_W-1:0]   saturation;
		logic [LIGHT_W-1:0] lightness;
	} hsl_t;

	// sector code times 512 gives the hue base
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic              qbit;
	} div_step_t;

	// one restoring division step: shift in one dividend bit, trial subtract
	function automatic div_step_t div_step(input logic [CHAN_W-1:0] rem,
	                                       input logic              din,
	                                       input logic [CHAN_W-1:0] divisor);
		logic [CHAN_W:0] trial;
		div_step_t       res;
		trial = {rem, din};
		if (trial >= {1'b0, divisor}) begin
			res.rem  = CHAN_W'(trial - {1'b0, divisor});
			res.qbit = 1'b1;
		end else begin
			res.rem  = trial[CHAN_W-1:0];
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/rgb_to_hsl_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_top
// Pipelined fixed-point RGB to HSL conversion, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB pixel per beat and returns hue (1/256 sextant, 0..1535),
// saturation (Q0.12, 0..4096) and lightness (max+min, 0..510). The block
// accepts a new pixel every clock while the output side takes results. The
// pipeline has one stage for max/min/sector selection, 13 stages of two
// restoring dividers (saturation resolves one quotient bit per stage, hue one
// bit per stage in the first HUE_QBITS stages only; the 13-bit saturation
// quotient sets the depth), and one output stage that forms the hue. The whole
// pipeline holds when the output beat is not taken, so nothing is dropped.
module rgb_to_hsl_converter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  rgbhsl_pkg::rgb_t    pixel,
	output logic                hsl_valid,
	input  logic                hsl_ready,
	output rgbhsl_pkg::hsl_t    hsl
);
	import rgbhsl_pkg::*;

	// global advance: the output register is free or being drained this cycle
	logic adv;
	logic out_valid_q;
	hsl_t out_data_q;

	assign adv         = !out_valid_q || hsl_ready;
	assign pixel_ready = adv;
	assign hsl_valid   = out_valid_q;
	assign hsl         = out_data_q;

	// ------------------------------------------------------------------
	// Stage 1: max, min, lightness, divisors and hue sector
	// ------------------------------------------------------------------
	logic [CHAN_W-1:0]  mx, mn, delta, den, absd;
	logic [LIGHT_W-1:0] sum;
	logic signed [CHAN_W:0] diff;
	sector_t            sector;

	always_comb begin
		mx = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx)  mx = pixel.blue;
		mn = pixel.red;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn)  mn = pixel.blue;

		sum   = {1'b0, mx} + {1'b0, mn};
		delta = mx - mn;
		// saturation divisor: sum at or below half scale, else its mirror
		if (sum <= LIGHT_HALF) begin
			den = sum[CHAN_W-1:0];
		end else begin
			den = CHAN_W'(LIGHT_FULL - sum);
		end

		// first channel equal to max wins the sector
		if (pixel.red == mx) begin
			sector = SEC_RED;
			diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green == mx) begin
			sector = SEC_GREEN;
			diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			sector = SEC_BLUE;
			diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
		absd = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
	end

	logic               valid_s1;
	logic [LIGHT_W-1:0] sum_s1;
	logic [CHAN_W-1:0]  delta_s1, den_s1, absd_s1;
	logic               neg_s1;
	sector_t            sector_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1    <= sum;
			delta_s1  <= delta;
			den_s1    <= den;
			absd_s1   <= absd;
			neg_s1    <= diff[CHAN_W];
			sector_s1 <= sector;
		end
	end

	// ------------------------------------------------------------------
	// Divider stages: saturation = (delta << 12) / den,
	// hue fraction = (|diff| << 8) / delta, one quotient bit per stage.
	// Initial remainders are the operand's upper 7 bits; its lsb is the
	// first bit shifted in, followed by zeros.
	// ------------------------------------------------------------------
	logic                 valid_s   [SAT_QBITS];
	logic [LIGHT_W-1:0]   sum_s     [SAT_QBITS];
	logic [CHAN_W-1:0]    delta_s   [SAT_QBITS];
	logic [CHAN_W-1:0]    den_s     [SAT_QBITS];
	logic                 neg_s     [SAT_QBITS];
	sector_t              sector_s  [SAT_QBITS];
	logic [CHAN_W-1:0]    sat_rem_s [SAT_QBITS];
	logic [SAT_W-1:0]     sat_q_s   [SAT_QBITS];
	logic [CHAN_W-1:0]    hue_rem_s [SAT_QBITS];
	logic [HUE_QBITS-1:0] hue_q_s   [SAT_QBITS];

	for (genvar k = 0; k < SAT_QBITS; k++) begin : g_div
		logic                 p_valid;
		logic [LIGHT_W-1:0]   p_sum;
		logic [CHAN_W-1:0]    p_delta, p_den, p_sat_rem, p_hue_rem;
		logic                 p_neg, sat_din, hue_din;
		sector_t              p_sector;
		logic [SAT_W-1:0]     p_sat_q;
		logic [HUE_QBITS-1:0] p_hue_q;
		div_step_t            sat_st, hue_st;

		if (k == 0) begin : g_first
			assign p_valid   = valid_s1;
			assign p_sum     = sum_s1;
			assign p_delta   = delta_s1;
			assign p_den     = den_s1;
			assign p_neg     = neg_s1;
			assign p_sector  = sector_s1;
			assign p_sat_rem = {1'b0, delta_s1[CHAN_W-1:1]};
			assign p_hue_rem = {1'b0, absd_s1[CHAN_W-1:1]};
			assign p_sat_q   = '0;
			assign p_hue_q   = '0;
			assign sat_din   = delta_s1[0];
			assign hue_din   = absd_s1[0];
		end else begin : g_next
			assign p_valid   = valid_s[k-1];
			assign p_sum     = sum_s[k-1];
			assign p_delta   = delta_s[k-1];
			assign p_den     = den_s[k-1];
			assign p_neg     = neg_s[k-1];
			assign p_sector  = sector_s[k-1];
			assign p_sat_rem = sat_rem_s[k-1];
			assign p_hue_rem = hue_rem_s[k-1];
			assign p_sat_q   = sat_q_s[k-1];
			assign p_hue_q   = hue_q_s[k-1];
			assign sat_din   = 1'b0;
			assign hue_din   = 1'b0;
		end

		assign sat_st = div_step(p_sat_rem, sat_din, p_den);
		assign hue_st = div_step(p_hue_rem, hue_din, p_delta);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= p_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s[k]     <= p_sum;
				delta_s[k]   <= p_delta;
				den_s[k]     <= p_den;
				neg_s[k]     <= p_neg;
				sector_s[k]  <= p_sector;
				sat_rem_s[k] <= sat_st.rem;
				sat_q_s[k]   <= {p_sat_q[SAT_W-2:0], sat_st.qbit};
				// hue divider finishes early; later stages just carry it
				if (k < HUE_QBITS) begin
					hue_rem_s[k] <= hue_st.rem;
					hue_q_s[k]   <= {p_hue_q[HUE_QBITS-2:0], hue_st.qbit};
				end else begin
					hue_rem_s[k] <= p_hue_rem;
					hue_q_s[k]   <= p_hue_q;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: hue = sector*512 +/- fraction, floored, wrapped
	// ------------------------------------------------------------------
	localparam int L = SAT_QBITS - 1;

	logic        grey;
	logic [9:0]  mag;
	logic [11:0] hbase, hraw, hwrap;

	always_comb begin
		grey  = (delta_s[L] == '0);
		// negative fraction floors away from zero when a remainder is left
		mag   = {1'b0, hue_q_s[L]} + {9'd0, neg_s[L] && (hue_rem_s[L] != '0)};
		hbase = {1'b0, sector_s[L], 9'd0};
		hraw  = neg_s[L] ? (hbase - {2'b00, mag}) : (hbase + {2'b00, mag});
		hwrap = hraw[11] ? (hraw + HUE_FULL) : hraw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.lightness  <= sum_s[L];
			out_data_q.saturation <= grey ? '0 : sat_q_s[L];
			out_data_q.hue        <= grey ? '0 : hwrap[HUE_W-1:0];
		end
	end

endmodule
